// ----- rtl/core/dda_pkg.sv -----
package dda_pkg;

   localparam int DELTA_BITS    = 16;
   localparam int INTERVAL_BITS = 32;
   localparam int MS_BITS       = 9;
   localparam int MICROSTEP_MAX = 256;
   localparam int REQ_BITS      = 3;
   localparam int CSR_IDX_BITS  = 1;

   // scaled magnitude width and raw product width
   localparam int MAG_BITS  = DELTA_BITS + 7;
   localparam int ABS_BITS  = DELTA_BITS + 1;
   localparam int PROD_BITS = ABS_BITS + MS_BITS;
   localparam int ERR_BITS  = MAG_BITS + 1;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_TICK   = 3'd0,
      REQ_START  = 3'd1,
      REQ_PAUSE  = 3'd2,
      REQ_RESUME = 3'd3,
      REQ_ABORT  = 3'd4
   } req_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MICROSTEPS_A = 1'b0,
      CSR_MICROSTEPS_B = 1'b1
   } csr_index_type;

   // input word after magnitude scaling
   typedef struct packed {
      logic [REQ_BITS-1:0]      code;
      logic [MAG_BITS-1:0]      mag_a;
      logic [MAG_BITS-1:0]      mag_b;
      logic                     fwd_a;
      logic                     fwd_b;
      logic [INTERVAL_BITS-1:0] interval;
   } dda_scaled_type;

   typedef struct packed {
      logic step_a;
      logic dir_a;
      logic step_b;
      logic dir_b;
      logic busy_res;
      logic held;
      logic move_done;
      logic rejected;
   } dda_result_type;

endpackage

// ----- rtl/core/dda_req_if.sv -----
interface dda_req_if import dda_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic [REQ_BITS-1:0]             req_type;
   logic signed [DELTA_BITS-1:0]    delta_a;
   logic signed [DELTA_BITS-1:0]    delta_b;
   logic [INTERVAL_BITS-1:0]        step_interval;

   modport source (output valid, req_type, delta_a, delta_b, step_interval, input ready);
   modport sink   (input valid, req_type, delta_a, delta_b, step_interval, output ready);
endinterface

// ----- rtl/core/dda_rsp_if.sv -----
interface dda_rsp_if import dda_pkg::*; ();
   logic valid;
   logic ready;
   logic step_a;
   logic dir_a;
   logic step_b;
   logic dir_b;
   logic busy_res;
   logic held;
   logic move_done;
   logic rejected;

   modport source (output valid, step_a, dir_a, step_b, dir_b, busy_res, held, move_done,
                   rejected, input ready);
   modport sink   (input valid, step_a, dir_a, step_b, dir_b, busy_res, held, move_done,
                   rejected, output ready);
endinterface

// ----- rtl/core/dda_csr_if.sv -----
interface dda_csr_if import dda_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [MS_BITS-1:0]      wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- rtl/core/dda_csr.sv -----
module dda_csr import dda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   dda_csr_if.sink            csr_ch,
   output logic [MS_BITS-1:0] ms_a,
   output logic [MS_BITS-1:0] ms_b
);

   logic [MS_BITS-1:0] ms_a_ff, ms_a_in;
   logic [MS_BITS-1:0] ms_b_ff, ms_b_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      ms_a_in = ms_a_ff;
      ms_b_in = ms_b_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_MICROSTEPS_A: ms_a_in = csr_ch.wdata;
            CSR_MICROSTEPS_B: ms_b_in = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_a_ff <= MS_BITS'(16);
         ms_b_ff <= MS_BITS'(16);
      end else begin
         ms_a_ff <= ms_a_in;
         ms_b_ff <= ms_b_in;
      end
   end

   assign ms_a = ms_a_ff;
   assign ms_b = ms_b_ff;

endmodule

// ----- rtl/core/dda_scale.sv -----
module dda_scale import dda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   dda_req_if.sink            req_ch,
   input  logic [MS_BITS-1:0] ms_a,
   input  logic [MS_BITS-1:0] ms_b,
   input  logic               take,
   output logic               s1_valid,
   output dda_scaled_type     s1
);

   logic           valid_ff, valid_in;
   dda_scaled_type word_ff, word_in;

   function automatic logic [MS_BITS-1:0] clamp_ms(input logic [MS_BITS-1:0] v);
      logic [MS_BITS-1:0] r;
      r = v;
      if (v == '0)
         r = MS_BITS'(1);
      else if (v > MS_BITS'(MICROSTEP_MAX))
         r = MS_BITS'(MICROSTEP_MAX);
      return r;
   endfunction

   // |delta| * microsteps, saturated to the magnitude width
   function automatic logic [MAG_BITS-1:0] scale_mag(input logic [DELTA_BITS-1:0] d,
                                                     input logic [MS_BITS-1:0] ms);
      logic [ABS_BITS-1:0]  ext;
      logic [ABS_BITS-1:0]  mag;
      logic [PROD_BITS-1:0] prod;
      logic [MAG_BITS-1:0]  r;
      ext  = {d[DELTA_BITS-1], d};
      mag  = ext[ABS_BITS-1] ? (~ext + ABS_BITS'(1)) : ext;
      prod = PROD_BITS'(mag) * PROD_BITS'(clamp_ms(ms));
      if (prod[PROD_BITS-1:MAG_BITS] != '0)
         r = '1;
      else
         r = prod[MAG_BITS-1:0];
      return r;
   endfunction

   assign req_ch.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_ch.valid && req_ch.ready) begin
         valid_in         = 1'b1;
         word_in.code     = req_ch.req_type;
         word_in.mag_a    = scale_mag(req_ch.delta_a, ms_a);
         word_in.mag_b    = scale_mag(req_ch.delta_b, ms_b);
         word_in.fwd_a    = !req_ch.delta_a[DELTA_BITS-1];
         word_in.fwd_b    = !req_ch.delta_b[DELTA_BITS-1];
         word_in.interval = (req_ch.step_interval == '0) ? INTERVAL_BITS'(1)
                                                         : req_ch.step_interval;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign s1_valid = valid_ff;
   assign s1       = word_ff;

endmodule

// ----- rtl/core/dda_engine.sv -----
module dda_engine import dda_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           s1_valid,
   input  dda_scaled_type s1,
   output logic           take,
   dda_rsp_if.source      rsp_ch
);

   logic [MAG_BITS-1:0]      abs_a_ff, abs_a_in;
   logic [MAG_BITS-1:0]      abs_b_ff, abs_b_in;
   logic [MAG_BITS-1:0]      major_ff, major_in;
   logic [MAG_BITS-1:0]      index_ff, index_in;
   logic [ERR_BITS-1:0]      err_a_ff, err_a_in;
   logic [ERR_BITS-1:0]      err_b_ff, err_b_in;
   logic [1:0]               dir_ff, dir_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;
   logic [INTERVAL_BITS-1:0] wait_ff, wait_in;
   logic                     busy_ff, busy_in;
   logic                     paused_ff, paused_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dda_result_type           rsp_ff, rsp_in;

   // one step of the line, from the stored state
   logic [ERR_BITS-1:0] sum_a, sum_b, it_err_a, it_err_b;
   logic [MAG_BITS-1:0] it_index;
   logic                it_step_a, it_step_b, it_done;

   // first step of a new move, straight from the scaled word
   logic [MAG_BITS-1:0] st_major;
   logic                st_step_a, st_step_b;

   logic step_a, step_b, done, rej;

   assign take = s1_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      sum_a     = err_a_ff + ERR_BITS'(abs_a_ff);
      sum_b     = err_b_ff + ERR_BITS'(abs_b_ff);
      it_step_a = sum_a >= ERR_BITS'(major_ff);
      it_step_b = sum_b >= ERR_BITS'(major_ff);
      it_err_a  = it_step_a ? sum_a - ERR_BITS'(major_ff) : sum_a;
      it_err_b  = it_step_b ? sum_b - ERR_BITS'(major_ff) : sum_b;
      it_index  = index_ff + MAG_BITS'(1);
      it_done   = it_index >= major_ff;

      st_major  = (s1.mag_a >= s1.mag_b) ? s1.mag_a : s1.mag_b;
      // error starts at the axis magnitude, so only the major axis steps; on a tie both axes step
      st_step_a = s1.mag_a >= s1.mag_b;
      st_step_b = s1.mag_b >= s1.mag_a;
   end

   always_comb begin
      abs_a_in    = abs_a_ff;
      abs_b_in    = abs_b_ff;
      major_in    = major_ff;
      index_in    = index_ff;
      err_a_in    = err_a_ff;
      err_b_in    = err_b_ff;
      dir_in      = dir_ff;
      interval_in = interval_ff;
      wait_in     = wait_ff;
      busy_in     = busy_ff;
      paused_in   = paused_ff;
      step_a      = 1'b0;
      step_b      = 1'b0;
      done        = 1'b0;
      rej         = 1'b0;

      unique case (s1.code)
         REQ_START: begin
            if (busy_ff) begin
               rej = 1'b1;
            end else begin
               abs_a_in    = s1.mag_a;
               abs_b_in    = s1.mag_b;
               major_in    = st_major;
               dir_in      = {s1.fwd_b, s1.fwd_a};
               interval_in = s1.interval;
               if (st_major == '0) begin
                  index_in = '0;
                  err_a_in = '0;
                  err_b_in = '0;
                  wait_in  = '0;
                  done     = 1'b1;
               end else begin
                  step_a   = st_step_a;
                  step_b   = st_step_b;
                  err_a_in = st_step_a ? '0 : ERR_BITS'(s1.mag_a);
                  err_b_in = st_step_b ? '0 : ERR_BITS'(s1.mag_b);
                  index_in = MAG_BITS'(1);
                  wait_in  = s1.interval - INTERVAL_BITS'(1);
                  done     = st_major == MAG_BITS'(1);
                  busy_in  = !done;
               end
            end
         end
         REQ_PAUSE: begin
            if (busy_ff)
               paused_in = 1'b1;
         end
         REQ_RESUME, REQ_TICK: begin
            if (busy_ff && (s1.code == REQ_RESUME ? paused_ff : !paused_ff)) begin
               if (s1.code == REQ_TICK && wait_ff != '0) begin
                  wait_in = wait_ff - INTERVAL_BITS'(1);
               end else begin
                  paused_in = 1'b0;
                  step_a    = it_step_a;
                  step_b    = it_step_b;
                  err_a_in  = it_err_a;
                  err_b_in  = it_err_b;
                  index_in  = it_index;
                  wait_in   = interval_ff - INTERVAL_BITS'(1);
                  done      = it_done;
                  busy_in   = !it_done;
               end
            end
         end
         REQ_ABORT: begin
            if (busy_ff) begin
               busy_in   = 1'b0;
               paused_in = 1'b0;
               wait_in   = '0;
               done      = 1'b1;
            end
         end
         default: ;
      endcase

      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff;
      if (take) begin
         rsp_valid_in     = 1'b1;
         rsp_in.step_a    = step_a;
         rsp_in.dir_a     = dir_in[0];
         rsp_in.step_b    = step_b;
         rsp_in.dir_b     = dir_in[1];
         rsp_in.busy_res  = busy_in;
         rsp_in.held      = paused_in;
         rsp_in.move_done = done;
         rsp_in.rejected  = rej;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_a_ff     <= '0;
         abs_b_ff     <= '0;
         major_ff     <= '0;
         index_ff     <= '0;
         err_a_ff     <= '0;
         err_b_ff     <= '0;
         dir_ff       <= 2'b11;
         interval_ff  <= INTERVAL_BITS'(1);
         wait_ff      <= '0;
         busy_ff      <= 1'b0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            abs_a_ff    <= abs_a_in;
            abs_b_ff    <= abs_b_in;
            major_ff    <= major_in;
            index_ff    <= index_in;
            err_a_ff    <= err_a_in;
            err_b_ff    <= err_b_in;
            dir_ff      <= dir_in;
            interval_ff <= interval_in;
            wait_ff     <= wait_in;
            busy_ff     <= busy_in;
            paused_ff   <= paused_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.step_a    = rsp_ff.step_a;
   assign rsp_ch.dir_a     = rsp_ff.dir_a;
   assign rsp_ch.step_b    = rsp_ff.step_b;
   assign rsp_ch.dir_b     = rsp_ff.dir_b;
   assign rsp_ch.busy_res  = rsp_ff.busy_res;
   assign rsp_ch.held      = rsp_ff.held;
   assign rsp_ch.move_done = rsp_ff.move_done;
   assign rsp_ch.rejected  = rsp_ff.rejected;

endmodule

// ----- rtl/core/two_axis_dda_step_generator_unit.sv -----
// Two-axis line stepper. Every req word (tick, start, pause, resume, abort)
// gives exactly one rsp word with step pulses, directions and move status.
// Ticks are the time base and may arrive every clock; a move steps once per
// step_interval ticks, starting on the start or resume word itself.
// Throughput: one word per cycle while rsp is ready. A req word is registered
// first in the input stage (microstep multiply), then in the line engine, whose
// state loop (add, compare, subtract) closes combinationally between its registers.
// Microstep settings are written over the csr channel, which is always ready;
// write them only while no word is in flight. Both reset to 16.
// Reset (synchronous) empties both stages, drops any move and sets both
// directions forward.
// A stalled rsp holds its word; the input stage then holds one more word and
// req ready falls until the rsp side takes the waiting word.
module two_axis_dda_step_generator_unit import dda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dda_req_if.sink    req_ch,
   dda_rsp_if.source  rsp_ch,
   dda_csr_if.sink    csr_ch
);

   logic [MS_BITS-1:0] ms_a, ms_b;
   logic               take;
   logic               s1_valid;
   dda_scaled_type     s1;

   dda_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .ms_a   (ms_a),
      .ms_b   (ms_b)
   );

   dda_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .ms_a     (ms_a),
      .ms_b     (ms_b),
      .take     (take),
      .s1_valid (s1_valid),
      .s1       (s1)
   );

   dda_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .take     (take),
      .rsp_ch   (rsp_ch)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("rsp word valid straight after reset");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.move_done) |-> !rsp_ch.busy_res)
      else $error("move reported done while still busy");

   a_held_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.held) |-> rsp_ch.busy_res)
      else $error("held without a move in progress");

   a_step_in_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.step_a || rsp_ch.step_b))
         |-> ((rsp_ch.busy_res && !rsp_ch.held) || rsp_ch.move_done))
      else $error("step pulse outside a running move");

   a_take_needs_slot: assert property (@(posedge clock) disable iff (reset)
      take |-> (s1_valid && (!rsp_ch.valid || rsp_ch.ready)))
      else $error("engine took a word with no free rsp slot");

endmodule
